// ===== design/rmps_pkg.sv =====
// Package with the shared sizes, codes and types of the rate-monotonic scheduler.
package rmps_pkg;

	localparam int READY_DEPTH = 16;
	localparam int TIME_WIDTH  = 32;
	localparam int CNT_W       = $clog2(READY_DEPTH + 1);

	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_ARRIVAL = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  job_type;
		logic [15:0] period;
		logic [15:0] compute_ticks;
	} item_t;

	typedef struct packed {
		logic [7:0]  running_type;
		logic        preempted;
		logic        done_valid;
		logic [7:0]  done_type;
		logic [31:0] done_response;
		logic        dropped;
	} result_t;

	typedef struct packed {
		logic [7:0]            job_type;
		logic [15:0]           period;
		logic [15:0]           remaining;
		logic [TIME_WIDTH-1:0] arrival;
	} entry_t;

	// Command broadcast to every cell of the ready chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_cmd_t;

endpackage

// ===== design/rmps_if.sv =====
// Handshake interfaces for the item and result channels of the scheduler.
interface rmps_item_if;
	logic               valid;
	logic               ready;
	rmps_pkg::item_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rmps_result_if;
	logic               valid;
	logic               ready;
	rmps_pkg::result_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/rmps_cell.sv =====
// One cell of the sorted ready chain: holds one entry and shifts with its neighbors.
module rmps_cell (
	input  logic                clk,
	input  rmps_pkg::cell_cmd_t cmd,
	input  logic                occ,
	input  logic [15:0]         key,
	input  rmps_pkg::entry_t    new_ent,
	input  rmps_pkg::entry_t    left_ent,
	input  logic                left_ahead,
	input  rmps_pkg::entry_t    right_ent,
	output rmps_pkg::entry_t    ent,
	output logic                ahead
);

	rmps_pkg::entry_t ent_q;

	// The new entry lands at or ahead of this cell when the cell is empty or
	// holds a strictly longer period; this keeps equal periods in arrival order.
	assign ahead = !occ || (ent_q.period > key);
	assign ent   = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && ahead) begin
			ent_q <= left_ahead ? left_ent : new_ent;
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

// ===== design/rate_monotonic_preemptive_scheduler_top.sv =====
// Top level of the rate-monotonic preemptive scheduler with its chain of ready cells.
//
//  channel   dir   payload            transfer when
//  item      in    rmps_pkg::item_t   item.valid && item.ready
//  result    out   rmps_pkg::result_t result.valid && result.ready
//
// Every item is handled in the cycle of its transfer: one item per cycle while the result is taken.
// The ready store is a chain of READY_DEPTH cells; a pop shifts it, an insert from its slot on, in that cycle.
// The result sits in an output register; a new item is taken while it is
// empty or being taken. Reset clears time, the running job and the fill count;
// the cells themselves hold no reset.
module rate_monotonic_preemptive_scheduler_top (
	input  logic                 clk,
	input  logic                 arst_n,
	rmps_item_if.sink            item,
	rmps_result_if.source        result
);

	localparam int DEPTH = rmps_pkg::READY_DEPTH;
	localparam int TW    = rmps_pkg::TIME_WIDTH;
	localparam int CW    = rmps_pkg::CNT_W;

	logic [TW-1:0]       now_q;
	logic                run_valid_q;
	rmps_pkg::entry_t    run_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q;
	rmps_pkg::result_t   res_q;

	logic                fire;
	logic [TW-1:0]       now_n;
	logic                run_valid_n;
	rmps_pkg::entry_t    run_n;
	logic [CW-1:0]       cnt_n;
	rmps_pkg::result_t   res_n;
	rmps_pkg::cell_cmd_t cmd;
	rmps_pkg::entry_t    ins_ent;
	rmps_pkg::entry_t    arr_ent;
	logic [15:0]         ct;
	logic [TW-1:0]       diff;

	rmps_pkg::entry_t    cell_ent [DEPTH];
	logic                cell_ahead [DEPTH];

	assign fire         = item.valid && item.ready;
	assign item.ready   = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.payload = res_q;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			rmps_pkg::entry_t left_ent;
			rmps_pkg::entry_t right_ent;
			logic             left_ahead;
			logic             occ;

			assign occ = CW'(gi) < cnt_q;
			if (gi == 0) begin : g_first
				assign left_ent   = ins_ent;
				assign left_ahead = 1'b0;
			end else begin : g_mid
				assign left_ent   = cell_ent[gi-1];
				assign left_ahead = cell_ahead[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_ent = '0;
			end else begin : g_inner
				assign right_ent = cell_ent[gi+1];
			end

			rmps_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occ        (occ),
				.key        (ins_ent.period),
				.new_ent    (ins_ent),
				.left_ent   (left_ent),
				.left_ahead (left_ahead),
				.right_ent  (right_ent),
				.ent        (cell_ent[gi]),
				.ahead      (cell_ahead[gi])
			);
		end
	endgenerate

	always_comb begin
		ct = (item.payload.compute_ticks == 16'd0) ? 16'd1 : item.payload.compute_ticks;
		arr_ent.job_type  = item.payload.job_type;
		arr_ent.period    = item.payload.period;
		arr_ent.remaining = ct;
		arr_ent.arrival   = now_q;

		now_n       = now_q;
		run_valid_n = run_valid_q;
		run_n       = run_q;
		cnt_n       = cnt_q;
		cmd         = '0;
		ins_ent     = arr_ent;
		res_n       = '0;
		diff        = now_q + TW'(1) - run_q.arrival;

		if (item.payload.kind == rmps_pkg::KIND_ARRIVAL) begin
			if (!run_valid_q) begin
				run_valid_n = 1'b1;
				run_n       = arr_ent;
			end else if (cnt_q == CW'(DEPTH)) begin
				res_n.dropped = 1'b1;
			end else if (item.payload.period < run_q.period) begin
				// The displaced job goes back into the chain, sorted by its own period.
				ins_ent         = run_q;
				cmd.ins         = fire;
				cnt_n           = cnt_q + CW'(1);
				run_n           = arr_ent;
				res_n.preempted = 1'b1;
			end else begin
				cmd.ins = fire;
				cnt_n   = cnt_q + CW'(1);
			end
		end else begin
			now_n = now_q + TW'(1);
			if (run_valid_q) begin
				if (run_q.remaining <= 16'd1) begin
					res_n.done_valid    = 1'b1;
					res_n.done_type     = run_q.job_type;
					res_n.done_response = 32'(diff);
					if (cnt_q != '0) begin
						run_n   = cell_ent[0];
						cmd.pop = fire;
						cnt_n   = cnt_q - CW'(1);
					end else begin
						run_valid_n = 1'b0;
						run_n       = '0;
					end
				end else begin
					run_n.remaining = run_q.remaining - 16'd1;
				end
			end
		end

		res_n.running_type = run_valid_n ? run_n.job_type : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			run_valid_q <= 1'b0;
			run_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				now_q       <= now_n;
				run_valid_q <= run_valid_n;
				run_q       <= run_n;
				cnt_q       <= cnt_n;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("ready count beyond store depth");

	a_store_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> run_valid_q)
		else $error("ready entries while processor idle");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.payload.kind == rmps_pkg::KIND_ARRIVAL && run_valid_q
		&& cnt_q == CW'(DEPTH) |=> out_valid_q && res_q.dropped && $stable(cnt_q))
		else $error("arrival on full store not dropped");

	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_valid |-> !res_q.preempted && !res_q.dropped)
		else $error("completion flagged together with arrival flags");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.payload.kind == rmps_pkg::KIND_TICK && !run_valid_q
		|=> !run_valid_q && cnt_q == '0)
		else $error("tick while idle changed the schedule");
`endif

endmodule
